// File: rtl/plpm_pkg.sv
package plpm_pkg;

    localparam int TABLE_DEPTH  = 64;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CURVE_POINTS = 60;

    localparam int POWER_W = 16;
    localparam int ENT_W   = 7;
    localparam int COEF_W  = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        REGION_BELOW  = 2'd0,
        REGION_INTERP = 2'd1,
        REGION_QUAD   = 2'd2
    } t_region;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRIES     = 2'd0,
        CFG_QUAD_CONST  = 2'd1,
        CFG_QUAD_LINEAR = 2'd2,
        CFG_QUAD_SQUARE = 2'd3
    } t_cfg_idx;

    localparam logic [ENT_W-1:0]         ENTRIES_RST     = 7'd60;
    localparam logic signed [COEF_W-1:0] QUAD_CONST_RST  = -32'sd94787;
    localparam logic signed [COEF_W-1:0] QUAD_LINEAR_RST = 32'sd64000;
    localparam logic signed [COEF_W-1:0] QUAD_SQUARE_RST = -32'sd233;

    localparam logic [POWER_W-1:0] CURVE_IN [CURVE_POINTS] = '{
        16'd218,  16'd279,  16'd308,  16'd329,  16'd361,
        16'd395,  16'd429,  16'd472,  16'd499,  16'd529,
        16'd558,  16'd589,  16'd609,  16'd634,  16'd640,
        16'd676,  16'd684,  16'd689,  16'd719,  16'd722,
        16'd753,  16'd773,  16'd842,  16'd960,  16'd998,
        16'd1065, 16'd1149, 16'd1203, 16'd1242, 16'd1293,
        16'd1380, 16'd1505, 16'd1536, 16'd1638, 16'd1756,
        16'd1864, 16'd1910, 16'd2125, 16'd2135, 16'd2273,
        16'd2458, 16'd2478, 16'd2647, 16'd2711, 16'd2726,
        16'd2765, 16'd2918, 16'd3021, 16'd3131, 16'd3231,
        16'd3269, 16'd3328, 16'd3418, 16'd3448, 16'd3704,
        16'd3748, 16'd4045, 16'd4557, 16'd4915, 16'd5612
    };

    localparam logic [POWER_W-1:0] CURVE_OUT [CURVE_POINTS] = '{
        16'd0,    16'd59,   16'd87,   16'd115,  16'd148,
        16'd182,  16'd212,  16'd256,  16'd284,  16'd312,
        16'd340,  16'd369,  16'd389,  16'd412,  16'd417,
        16'd456,  16'd458,  16'd466,  16'd494,  16'd494,
        16'd520,  16'd543,  16'd602,  16'd701,  16'd740,
        16'd794,  16'd876,  16'd927,  16'd957,  16'd1004,
        16'd1085, 16'd1203, 16'd1231, 16'd1329, 16'd1436,
        16'd1536, 16'd1577, 16'd1774, 16'd1779, 16'd1912,
        16'd2074, 16'd2084, 16'd2117, 16'd2158, 16'd2176,
        16'd2222, 16'd2355, 16'd2442, 16'd2547, 16'd2629,
        16'd2675, 16'd2726, 16'd2801, 16'd2834, 16'd3054,
        16'd3098, 16'd3354, 16'd3789, 16'd4096, 16'd4672
    };

    // entries past the built-in curve read as zero
    function automatic logic [POWER_W-1:0] bp_in_at(input logic [IDX_W-1:0] idx);
        if (int'(idx) < CURVE_POINTS) begin
            return CURVE_IN[idx];
        end
        return '0;
    endfunction

    function automatic logic signed [POWER_W-1:0] bp_out_at(input logic [IDX_W-1:0] idx);
        if (int'(idx) < CURVE_POINTS) begin
            return signed'(CURVE_OUT[idx]);
        end
        return '0;
    endfunction

endpackage

// File: rtl/plpm_in_if.sv
interface plpm_in_if;
    import plpm_pkg::*;

    logic               valid;
    logic               ready;
    logic [POWER_W-1:0] input_power;

    modport source (output valid, output input_power, input ready);
    modport sink   (input valid, input input_power, output ready);
endinterface

// File: rtl/plpm_out_if.sv
interface plpm_out_if;
    import plpm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [POWER_W-1:0] output_power;
    t_region                   region;

    modport source (output valid, output output_power, output region, input ready);
    modport sink   (input valid, input output_power, input region, output ready);
endinterface

// File: rtl/piecewise_linear_power_map_top.sv
// piecewise linear power map
// i_in carries one unsigned Q8.8 power sample per beat; o_out returns one beat
// per sample with the signed Q8.8 mapped power and a region code (below table,
// interpolated, quadratic). valid/ready handshakes on both sides.
// i_cfg_we/i_cfg_idx/i_cfg_data write the entry count and the three Q16.16
// quadratic coefficients; write them only while no sample is in flight.
// one sample is worked at a time; i_in.ready is high only when the sequencer
// is idle. the breakpoint search takes one table entry per cycle, up to the
// last segment in use. interpolation then adds one multiply on the shared
// 33x33 multiplier, a divider setup step, a restoring divider and a final
// add-and-saturate step; the quadratic path runs three multiplies on the same
// multiplier, a sum and a scaling step, and S_DONE loads the output register.
// the next sample can be accepted in the cycle after the result is loaded.
// the result sits in an output register; if the receiver stalls, the block
// still accepts and works the next sample and holds its result until the
// output register frees up.
// reset (synchronous, active low) restores the default 60-point curve count
// and coefficients and empties the output register.
module piecewise_linear_power_map_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    plpm_in_if.sink                          i_in,
    plpm_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [plpm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [plpm_pkg::COEF_W-1:0]      i_cfg_data
);
    import plpm_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_SEARCH   = 12'b0000_0000_0010,
        S_MUL_INT  = 12'b0000_0000_0100,
        S_DIV_INIT = 12'b0000_0000_1000,
        S_DIV      = 12'b0000_0001_0000,
        S_INT_FIN  = 12'b0000_0010_0000,
        S_MUL_SQ   = 12'b0000_0100_0000,
        S_MUL_C2   = 12'b0000_1000_0000,
        S_MUL_C1   = 12'b0001_0000_0000,
        S_SUM      = 12'b0010_0000_0000,
        S_QFIN     = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } t_state;

    localparam logic signed [63:0] T2_LIM    = 64'sd1 <<< 60;
    localparam logic signed [63:0] ROUND_Q   = 64'sd1 <<< 23;
    localparam logic [3:0]         DIV_LAST  = 4'd15;

    function automatic logic [IDX_W-1:0] last_index(input logic [ENT_W-1:0] n);
        int k;
        k = int'(n);
        if (k < 2) begin
            k = 2;
        end
        if (k > TABLE_DEPTH) begin
            k = TABLE_DEPTH;
        end
        return IDX_W'(k - 2);
    endfunction

    function automatic logic signed [POWER_W-1:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'sh7fff;
        end
        if (v < -64'sd32768) begin
            return 16'sh8000;
        end
        return v[POWER_W-1:0];
    endfunction

    // configuration
    logic [ENT_W-1:0]         r_entries;
    logic signed [COEF_W-1:0] r_c0;
    logic signed [COEF_W-1:0] r_c1;
    logic signed [COEF_W-1:0] r_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= ENTRIES_RST;
            r_c0      <= QUAD_CONST_RST;
            r_c1      <= QUAD_LINEAR_RST;
            r_c2      <= QUAD_SQUARE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ENTRIES:     r_entries <= i_cfg_data[ENT_W-1:0];
                CFG_QUAD_CONST:  r_c0 <= signed'(i_cfg_data);
                CFG_QUAD_LINEAR: r_c1 <= signed'(i_cfg_data);
                CFG_QUAD_SQUARE: r_c2 <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    t_state                    r_state;
    t_state                    n_state;
    logic [POWER_W-1:0]        r_x;
    logic [IDX_W-1:0]          r_idx;
    logic signed [POWER_W-1:0] r_a;
    logic signed [16:0]        r_diff;
    logic [POWER_W-1:0]        r_dx;
    logic [POWER_W-1:0]        r_d;
    logic [16:0]               r_den;
    logic                      r_neg;
    logic [16:0]               r_rem;
    logic [15:0]               r_nlo;
    logic [3:0]                r_step;
    logic signed [63:0]        r_prod;
    logic signed [63:0]        r_acc;
    logic signed [POWER_W-1:0] r_res;
    t_region                   r_region;

    logic                      r_out_valid;
    logic signed [POWER_W-1:0] r_out_power;
    t_region                   r_out_region;

    logic [IDX_W-1:0]   last_idx;
    logic [IDX_W-1:0]   idx1;
    logic               x_lt_first;
    logic               x_lt_next;
    logic               out_free;

    assign last_idx   = last_index(r_entries);
    assign idx1       = r_idx + IDX_W'(1);
    assign x_lt_first = r_x < bp_in_at('0);
    assign x_lt_next  = r_x < bp_in_at(idx1);
    assign out_free   = !r_out_valid || o_out.ready;

    // shared multiplier
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MUL_INT: begin
                mul_a = 33'(r_diff);
                mul_b = signed'({17'b0, r_dx});
            end
            S_MUL_SQ: begin
                mul_a = signed'({17'b0, r_x});
                mul_b = signed'({17'b0, r_x});
            end
            S_MUL_C2: begin
                mul_a = 33'(r_c2);
                mul_b = signed'({1'b0, r_prod[31:0]});
            end
            S_MUL_C1: begin
                mul_a = 33'(r_c1);
                mul_b = signed'({17'b0, r_x});
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // divider step and numerator setup
    logic [31:0] num_mag;
    logic [33:0] num_round;
    logic [17:0] trial;
    logic [17:0] trial_sub;
    logic        trial_ge;

    assign num_mag   = r_prod[63] ? 32'(-r_prod) : r_prod[31:0];
    assign num_round = {1'b0, num_mag, 1'b0} + {18'b0, r_d};
    assign trial     = {r_rem, r_nlo[15]};
    assign trial_ge  = trial >= {1'b0, r_den};
    assign trial_sub = trial - {1'b0, r_den};

    logic signed [17:0] q_signed;
    logic signed [17:0] int_sum;
    logic signed [63:0] t2_clamped;
    logic signed [63:0] q_shifted;

    assign q_signed   = r_neg ? -signed'({2'b0, r_nlo}) : signed'({2'b0, r_nlo});
    assign int_sum    = 18'(r_a) + q_signed;
    assign t2_clamped = (r_prod > T2_LIM) ? T2_LIM :
                        (r_prod < -T2_LIM) ? -T2_LIM : r_prod;
    assign q_shifted  = r_acc >>> 24;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_idx == '0 && x_lt_first) begin
                    n_state = S_DONE;
                end else if (x_lt_next) begin
                    n_state = S_MUL_INT;
                end else if (r_idx == last_idx) begin
                    n_state = S_MUL_SQ;
                end
            end
            S_MUL_INT:  n_state = S_DIV_INIT;
            S_DIV_INIT: n_state = S_DIV;
            S_DIV: begin
                if (r_step == DIV_LAST) begin
                    n_state = S_INT_FIN;
                end
            end
            S_INT_FIN:  n_state = S_DONE;
            S_MUL_SQ:   n_state = S_MUL_C2;
            S_MUL_C2:   n_state = S_MUL_C1;
            S_MUL_C1:   n_state = S_SUM;
            S_SUM:      n_state = S_QFIN;
            S_QFIN:     n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x   <= i_in.input_power;
                r_idx <= '0;
            end
            S_SEARCH: begin
                r_idx    <= idx1;
                r_res    <= '0;
                r_region <= (r_idx == '0 && x_lt_first) ? REGION_BELOW : REGION_QUAD;
                r_a      <= bp_out_at(r_idx);
                r_diff   <= 17'(bp_out_at(idx1)) - 17'(bp_out_at(r_idx));
                r_dx     <= r_x - bp_in_at(r_idx);
                r_d      <= bp_in_at(idx1) - bp_in_at(r_idx);
            end
            S_MUL_INT, S_MUL_SQ, S_MUL_C2: begin
                r_prod <= mul_p[63:0];
            end
            S_DIV_INIT: begin
                // quotient stays below 2^16, so the top part starts below the divisor
                r_rem  <= num_round[32:16];
                r_nlo  <= num_round[15:0];
                r_den  <= {r_d, 1'b0};
                r_neg  <= r_prod[63];
                r_step <= '0;
            end
            S_DIV: begin
                r_rem  <= trial_ge ? trial_sub[16:0] : trial[16:0];
                r_nlo  <= {r_nlo[14:0], trial_ge};
                r_step <= r_step + 4'd1;
            end
            S_INT_FIN: begin
                r_res    <= sat16(64'(int_sum));
                r_region <= REGION_INTERP;
            end
            S_MUL_C1: begin
                r_acc  <= t2_clamped;
                r_prod <= mul_p[63:0];
            end
            S_SUM: begin
                r_acc <= r_acc + (r_prod <<< 8) + (64'(r_c0) <<< 16) + ROUND_Q;
            end
            S_QFIN: begin
                r_res    <= sat16(q_shifted);
                r_region <= REGION_QUAD;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_power  <= r_res;
            r_out_region <= r_region;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.output_power = r_out_power;
    assign o_out.region       = r_out_region;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted again while a sample is in flight");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_idx <= last_idx))
        else $error("breakpoint search ran past the last entry in use");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_below_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_region == REGION_BELOW) |-> (r_out_power == '0))
        else $error("below-table result is not zero");

    a_region_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_region <= REGION_QUAD))
        else $error("illegal region code on output");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import plpm_pkg::*;

    localparam int unsigned RUN_LIMIT    = 1_500_000;
    localparam int          DRAIN_CYCLES = 100;
    localparam longint      SQ_LIM       = 64'sd1 <<< 60;
    localparam longint      SUM_LIM      = 64'sd1 <<< 40;
    localparam longint      HALF_LSB     = 64'sd1 <<< 23;

    localparam logic [POWER_W-1:0] CORNER_PTS [20] = '{
        16'd0,    16'd1,    16'd217,  16'd218,  16'd219,
        16'd278,  16'd279,  16'd308,  16'd640,  16'd676,
        16'd719,  16'd722,  16'd3000, 16'd5611, 16'd5612,
        16'd5613, 16'h7FFF, 16'h8000, 16'd20000, 16'hFFFF
    };

    typedef struct {
        logic [POWER_W-1:0]        sample;
        logic signed [POWER_W-1:0] power;
        t_region                   region;
    } t_mapped;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COEF_W-1:0]    i_cfg_data;

    plpm_in_if  in_bus ();
    plpm_out_if out_bus ();

    piecewise_linear_power_map_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the curve tables and the registers
    logic [POWER_W-1:0]        knee_in  [TABLE_DEPTH];
    logic signed [POWER_W-1:0] knee_out [TABLE_DEPTH];
    logic [ENT_W-1:0]          ent_cfg;
    logic signed [COEF_W-1:0]  q_const;
    logic signed [COEF_W-1:0]  q_linear;
    logic signed [COEF_W-1:0]  q_square;

    logic [POWER_W-1:0] feed_q [$];
    t_mapped            mapped_q [$];
    int unsigned        feed_gap;
    int unsigned        sink_gap;
    int unsigned        cycles = 0;
    int unsigned        mismatches = 0;
    bit                 in_took;
    bit                 calm;

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = CFG_ENTRIES;
        i_cfg_data           = '0;
        in_bus.valid         = 1'b0;
        in_bus.input_power   = '0;
        out_bus.ready        = 1'b0;
        feed_gap             = 0;
        sink_gap             = 0;
        in_took              = 1'b0;
        calm                 = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_mapped power_curve(input logic [POWER_W-1:0] x);
        t_mapped m;
        int      n, k, seg;
        longint  xv, span, ya, yb, num, t0, t1, t2, s, r;
        m.sample = x;
        m.power  = '0;
        m.region = REGION_BELOW;
        xv = longint'(x);
        n  = int'(ent_cfg);
        if (n < 2) n = 2;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        if (x < knee_in[0]) return m;
        // first knee strictly above the sample; zero entries never match
        seg = -1;
        for (k = 0; k + 1 < n; k++) begin
            if (seg < 0 && x < knee_in[k+1]) seg = k;
        end
        if (seg >= 0) begin
            m.region = REGION_INTERP;
            span = longint'(knee_in[seg+1]) - longint'(knee_in[seg]);
            ya   = longint'(knee_out[seg]);
            yb   = longint'(knee_out[seg+1]);
            num  = (yb - ya) * (xv - longint'(knee_in[seg]));
            // round half away from zero
            if (span <= 0) r = ya;
            else if (num >= 0) r = ya + (2 * num + span) / (2 * span);
            else r = ya - (-2 * num + span) / (2 * span);
        end else begin
            m.region = REGION_QUAD;
            t0 = longint'(q_const) * 65536;
            t1 = longint'(q_linear) * xv * 256;
            t2 = longint'(q_square) * (xv * xv);
            if (t2 > SQ_LIM) t2 = SQ_LIM;
            if (t2 < -SQ_LIM) t2 = -SQ_LIM;
            s = t0 + t1 + t2;
            if (s > SUM_LIM) s = SUM_LIM;
            if (s < -SUM_LIM) s = -SUM_LIM;
            // 2^-32 units down to Q8.8, ties toward +inf
            r = ((s + SUM_LIM + HALF_LSB) >>> 24) - 65536;
        end
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        m.power = r[POWER_W-1:0];
        return m;
    endfunction

    function automatic int unsigned pick_gap(input int unsigned longest);
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, longest);
    endfunction

    function automatic logic [POWER_W-1:0] pick_power();
        int unsigned r;
        int          k;
        r = $urandom_range(99);
        k = $urandom_range(CURVE_POINTS - 1);
        if (r < 35) return POWER_W'($urandom_range(6000));
        if (r < 55) return POWER_W'(int'(knee_in[k]) + int'($urandom_range(2)) - 1);
        if (r < 75) return POWER_W'($urandom_range(5612, 24000));
        return POWER_W'($urandom());
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [COEF_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_ENTRIES:     ent_cfg  = data[ENT_W-1:0];
            CFG_QUAD_CONST:  q_const  = data;
            CFG_QUAD_LINEAR: q_linear = data;
            CFG_QUAD_SQUARE: q_square = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_regs(input int ent, input int c0, input int c1, input int c2);
        write_reg(CFG_ENTRIES, COEF_W'(ent));
        write_reg(CFG_QUAD_CONST, COEF_W'(c0));
        write_reg(CFG_QUAD_LINEAR, COEF_W'(c1));
        write_reg(CFG_QUAD_SQUARE, COEF_W'(c2));
    endtask

    // queue random samples, then wait for the block to go quiet
    task automatic run_batch(input int count);
        repeat (count) feed_q.push_back(pick_power());
        while (feed_q.size() != 0 || in_bus.valid || mapped_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // sample driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_took) begin
            if (feed_gap != 0) begin
                in_bus.valid <= 1'b0;
                feed_gap     <= feed_gap - 1;
            end else if (feed_q.size() != 0) begin
                in_bus.valid       <= 1'b1;
                in_bus.input_power <= feed_q.pop_front();
                feed_gap           <= pick_gap(40);
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else if (sink_gap != 0) begin
            out_bus.ready <= 1'b0;
            sink_gap      <= sink_gap - 1;
        end else begin
            out_bus.ready <= 1'b1;
            sink_gap      <= pick_gap(120);
        end
    end

    always @(posedge i_clk) begin : beat_check
        t_mapped want;
        in_took = i_rst_n && in_bus.valid && in_bus.ready;
        if (in_took) begin
            mapped_q.push_back(power_curve(in_bus.input_power));
        end
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (mapped_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat: power %0d region %0d", $time,
                         out_bus.output_power, out_bus.region);
            end else begin
                want = mapped_q.pop_front();
                if (out_bus.output_power !== want.power || out_bus.region !== want.region) begin
                    mismatches++;
                    $display("%0t: input %0d: expected power %0d region %0d, got power %0d region %0d",
                             $time, want.sample, want.power, want.region,
                             out_bus.output_power, out_bus.region);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        // switch between idle-free stretches and gappy ones
        if (cycles % 256 == 0) calm <= ($urandom_range(3) == 0);
        if (cycles == RUN_LIMIT) begin
            $display("piecewise_linear_power_map_top test failed");
            $finish;
        end
    end

    initial begin : stim
        int k;
        for (k = 0; k < TABLE_DEPTH; k++) begin
            knee_in[k]  = (k < CURVE_POINTS) ? CURVE_IN[k] : '0;
            knee_out[k] = (k < CURVE_POINTS) ? signed'(CURVE_OUT[k]) : '0;
        end
        ent_cfg  = ENTRIES_RST;
        q_const  = QUAD_CONST_RST;
        q_linear = QUAD_LINEAR_RST;
        q_square = QUAD_SQUARE_RST;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset curve: knees, segment ends, top of table, full-scale samples
        foreach (CORNER_PTS[k]) feed_q.push_back(CORNER_PTS[k]);
        run_batch(150);

        // single segment
        load_regs(2, QUAD_CONST_RST, QUAD_LINEAR_RST, QUAD_SQUARE_RST);
        run_batch(160);

        // count above depth, coefficient extremes
        load_regs(127, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        run_batch(160);

        load_regs(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        run_batch(160);

        load_regs(1, 0, 0, 32'h8000_0000);
        run_batch(160);

        // full depth, coefficients small enough to stay mostly unsaturated
        load_regs(64, int'($urandom_range(0, 33554431)) - 16777216,
                  int'($urandom_range(0, 262143)) - 131072,
                  int'($urandom_range(0, 2047)) - 1024);
        run_batch(160);

        load_regs($urandom_range(0, 127), $urandom(), $urandom(), $urandom());
        run_batch(160);

        // partial table with near-default extrapolation
        load_regs($urandom_range(20, 59), QUAD_CONST_RST, QUAD_LINEAR_RST,
                  -233 + int'($urandom_range(0, 200)) - 100);
        run_batch(160);

        if (mismatches == 0) begin
            $display("piecewise_linear_power_map_top test passed");
        end else begin
            $display("piecewise_linear_power_map_top test failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/plpm_pkg.sv
rtl/plpm_in_if.sv
rtl/plpm_out_if.sv
rtl/piecewise_linear_power_map_top.sv
verif/tb.sv
